### hw/rtl/svt_pkg.sv
`timescale 1ns / 1ps
package svt_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int REG_W     = 48;
  localparam int COMP_W    = 16;

  // datapath widths, sized for the worst case of every operation
  localparam int P_W     = COMP_W + 1;        // first operand, holds a - r
  localparam int PROD1_W = COMP_W + P_W;      // 16 x 17 products
  localparam int U_W     = PROD1_W + 2;       // sum of three products
  localparam int W_W     = PROD1_W + 2;
  localparam int PROD2_W = COMP_W + U_W;      // 16 x 35 products
  localparam int S_W     = PROD2_W + 1;
  localparam int DV_W    = U_W + 1;

  localparam int RND_TOP  = 14;
  localparam int RND_BOT  = 22;
  localparam int SAT_W    = 32;
  localparam int E_FRAC   = 14;
  localparam int V_FRAC   = 8;

  localparam logic [2:0] OP_MOTION     = 3'd0;
  localparam logic [2:0] OP_INV_MOTION = 3'd1;
  localparam logic [2:0] OP_FORCE      = 3'd2;
  localparam logic [2:0] OP_INV_FORCE  = 3'd3;
  localparam logic [2:0] OP_POINT      = 3'd4;
  localparam logic [2:0] OP_INV_POINT  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_ROT_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS = 3'd3;

  // identity rotation, zero translation
  localparam logic [REG_W-1:0] ROT_0_RESET = 48'h0000_0000_4000;
  localparam logic [REG_W-1:0] ROT_1_RESET = 48'h0000_4000_0000;
  localparam logic [REG_W-1:0] ROT_2_RESET = 48'h4000_0000_0000;
  localparam logic [REG_W-1:0] TRANS_RESET = 48'h0000_0000_0000;

  // cyclic neighbours for the cross product
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [COMP_W-1:0] comp_0;
    logic signed [COMP_W-1:0] comp_1;
    logic signed [COMP_W-1:0] comp_2;
    logic signed [COMP_W-1:0] comp_3;
    logic signed [COMP_W-1:0] comp_4;
    logic signed [COMP_W-1:0] comp_5;
  } svt_in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_0;
    logic signed [COMP_W-1:0] out_1;
    logic signed [COMP_W-1:0] out_2;
    logic signed [COMP_W-1:0] out_3;
    logic signed [COMP_W-1:0] out_4;
    logic signed [COMP_W-1:0] out_5;
    logic                     saturated;
  } svt_out_t;

  typedef struct packed {
    logic [2:0][REG_W-1:0] rot;
    logic [REG_W-1:0]      trans;
  } svt_cfg_t;

  typedef struct packed {
    logic                valid;
    logic [2:0]          op;
    logic [2:0][U_W-1:0] u;
    logic [2:0][W_W-1:0] w;
  } svt_mid_t;

  typedef struct packed {
    logic                 valid;
    logic [2:0]           op;
    logic [2:0][DV_W-1:0] dv;
    logic [2:0][S_W-1:0]  s;
  } svt_fin_t;

  function automatic logic signed [COMP_W-1:0] get_field(input logic [REG_W-1:0] v,
                                                         input logic [1:0] j);
    return v[{j, 4'd0} +: COMP_W];
  endfunction

  function automatic logic is_inverse(input logic [2:0] op);
    return (op == OP_INV_MOTION) || (op == OP_INV_FORCE) || (op == OP_INV_POINT);
  endfunction

endpackage

### hw/rtl/spatial_vector_transform.sv
`timescale 1ns / 1ps
// Plucker transform of one six-component spatial vector per beat. A beat is taken at
// every clock edge where start is high; busy is always low, so a new vector may be
// issued on every cycle. Each result appears on result for one cycle with done high,
// in issue order, after passing through the six register stages (input select, first
// multiply bank, first adder tree, second multiply bank, second adder tree, round and
// saturate), the first of which loads at the start edge. There is no back-pressure: the
// result must be captured in the cycle it is shown. The rotation and translation
// registers take effect on the next edge and should only be written while no vector is
// in flight.
module spatial_vector_transform
  import svt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  svt_in_t              item,
  output logic                 done,
  output svt_out_t             result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  svt_cfg_t cfg;
  svt_mid_t mid;
  svt_fin_t fin;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot[0] <= ROT_0_RESET;
      cfg.rot[1] <= ROT_1_RESET;
      cfg.rot[2] <= ROT_2_RESET;
      cfg.trans  <= TRANS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROT_0: cfg.rot[0] <= cfg_data;
        REG_ROT_1: cfg.rot[1] <= cfg_data;
        REG_ROT_2: cfg.rot[2] <= cfg_data;
        REG_TRANS: cfg.trans  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  svt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start & ~busy),
    .in_beat  (item),
    .cfg      (cfg),
    .mid      (mid)
  );

  svt_back u_back (
    .clk (clk),
    .rst (rst),
    .mid (mid),
    .cfg (cfg),
    .fin (fin)
  );

  svt_round u_round (
    .clk    (clk),
    .rst    (rst),
    .fin    (fin),
    .done   (done),
    .result (result)
  );

endmodule

### hw/rtl/svt_front.sv
`timescale 1ns / 1ps
module svt_front
  import svt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  svt_in_t  in_beat,
  input  svt_cfg_t cfg,
  output svt_mid_t mid
);

  logic signed [COMP_W-1:0] e [3][3];
  logic signed [COMP_W-1:0] r [3];
  logic signed [COMP_W-1:0] a [3];
  logic signed [COMP_W-1:0] b [3];

  logic signed [P_W-1:0]    p_next [3];
  logic signed [COMP_W-1:0] q_next [3];

  logic                     s0_valid;
  logic [2:0]               s0_op;
  logic signed [P_W-1:0]    s0_p [3];
  logic signed [COMP_W-1:0] s0_q [3];

  logic                      inv0;
  logic signed [COMP_W-1:0]  mx [3][3];
  logic signed [COMP_W-1:0]  bx [3][3];
  logic signed [P_W-1:0]     by [3][3];
  logic signed [PROD1_W-1:0] pa_next [3][3];
  logic signed [PROD1_W-1:0] pb_next [3][3];

  logic                      s1_valid;
  logic [2:0]                s1_op;
  logic signed [PROD1_W-1:0] s1_pa [3][3];
  logic signed [PROD1_W-1:0] s1_pb [3][3];
  logic signed [COMP_W-1:0]  s1_q [3];

  logic                  inv1;
  logic signed [U_W-1:0] u_next [3];
  logic signed [W_W-1:0] w_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e[i][j] = get_field(cfg.rot[i], 2'(j));
      end
      r[i] = get_field(cfg.trans, 2'(i));
    end
    a[0] = in_beat.comp_0;
    a[1] = in_beat.comp_1;
    a[2] = in_beat.comp_2;
    b[0] = in_beat.comp_3;
    b[1] = in_beat.comp_4;
    b[2] = in_beat.comp_5;
  end

  // p is the vector that goes through the first rotation (and the cross in forward modes)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_next[i] = P_W'(a[i]);
      q_next[i] = b[i];
    end
    unique case (in_beat.operation)
      OP_FORCE, OP_INV_FORCE: begin
        for (int i = 0; i < 3; i++) begin
          p_next[i] = P_W'(b[i]);
          q_next[i] = a[i];
        end
      end
      OP_POINT: begin
        for (int i = 0; i < 3; i++) begin
          p_next[i] = P_W'(a[i]) - P_W'(r[i]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= in_valid;
    end
    s0_op <= in_beat.operation;
    s0_p  <= p_next;
    s0_q  <= q_next;
  end

  // second bank: rotation of q in inverse modes, r x p in forward modes
  always_comb begin
    inv0 = is_inverse(s0_op);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mx[i][j] = inv0 ? e[j][i] : e[i][j];
        pa_next[i][j] = PROD1_W'(mx[i][j]) * PROD1_W'(s0_p[j]);
        if (inv0) begin
          bx[i][j] = mx[i][j];
          by[i][j] = P_W'(s0_q[j]);
        end else if (j == 0) begin
          bx[i][j] = r[NXT[i]];
          by[i][j] = s0_p[PRV[i]];
        end else if (j == 1) begin
          bx[i][j] = r[PRV[i]];
          by[i][j] = s0_p[NXT[i]];
        end else begin
          bx[i][j] = '0;
          by[i][j] = '0;
        end
        pb_next[i][j] = PROD1_W'(bx[i][j]) * PROD1_W'(by[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
    s1_op <= s0_op;
    s1_pa <= pa_next;
    s1_pb <= pb_next;
    s1_q  <= s0_q;
  end

  always_comb begin
    inv1 = is_inverse(s1_op);
    for (int i = 0; i < 3; i++) begin
      u_next[i] = U_W'(s1_pa[i][0]) + U_W'(s1_pa[i][1]) + U_W'(s1_pa[i][2]);
      if (inv1) begin
        w_next[i] = W_W'(s1_pb[i][0]) + W_W'(s1_pb[i][1]) + W_W'(s1_pb[i][2]);
      end else begin
        w_next[i] = (W_W'(s1_q[i]) <<< V_FRAC) - (W_W'(s1_pb[i][0]) - W_W'(s1_pb[i][1]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid.valid <= 1'b0;
    end else begin
      mid.valid <= s1_valid;
    end
    mid.op <= s1_op;
    for (int i = 0; i < 3; i++) begin
      mid.u[i] <= u_next[i];
      mid.w[i] <= w_next[i];
    end
  end

endmodule

### hw/rtl/svt_back.sv
`timescale 1ns / 1ps
module svt_back
  import svt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  svt_mid_t mid,
  input  svt_cfg_t cfg,
  output svt_fin_t fin
);

  logic signed [COMP_W-1:0] e [3][3];
  logic signed [COMP_W-1:0] r [3];
  logic signed [U_W-1:0]    u [3];
  logic signed [W_W-1:0]    w [3];

  logic                      inv2;
  logic signed [COMP_W-1:0]  x [3][3];
  logic signed [U_W-1:0]     y [3][3];
  logic signed [PROD2_W-1:0] prod_next [3][3];

  logic                      s3_valid;
  logic [2:0]                s3_op;
  logic signed [PROD2_W-1:0] s3_prod [3][3];
  logic signed [U_W-1:0]     s3_u [3];
  logic signed [W_W-1:0]     s3_w [3];

  logic                   inv3;
  logic signed [DV_W-1:0] r_add [3];
  logic signed [DV_W-1:0] dv_next [3];
  logic signed [S_W-1:0]  s_next [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e[i][j] = get_field(cfg.rot[i], 2'(j));
      end
      r[i] = get_field(cfg.trans, 2'(i));
      u[i] = $signed(mid.u[i]);
      w[i] = $signed(mid.w[i]);
    end
  end

  // forward modes rotate the corrected vector, inverse modes take r x u
  always_comb begin
    inv2 = is_inverse(mid.op);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!inv2) begin
          x[i][j] = e[i][j];
          y[i][j] = w[j];
        end else if (j == 0) begin
          x[i][j] = r[NXT[i]];
          y[i][j] = u[PRV[i]];
        end else if (j == 1) begin
          x[i][j] = r[PRV[i]];
          y[i][j] = u[NXT[i]];
        end else begin
          x[i][j] = '0;
          y[i][j] = '0;
        end
        prod_next[i][j] = PROD2_W'(x[i][j]) * PROD2_W'(y[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= mid.valid;
    end
    s3_op   <= mid.op;
    s3_prod <= prod_next;
    s3_u    <= u;
    s3_w    <= w;
  end

  always_comb begin
    inv3 = is_inverse(s3_op);
    for (int i = 0; i < 3; i++) begin
      if (s3_op == OP_INV_POINT) begin
        r_add[i] = DV_W'(r[i]) <<< E_FRAC;
      end else begin
        r_add[i] = '0;
      end
      dv_next[i] = DV_W'(s3_u[i]) + r_add[i];
      if (inv3) begin
        s_next[i] = S_W'(s3_prod[i][0]) - S_W'(s3_prod[i][1]) + (S_W'(s3_w[i]) <<< V_FRAC);
      end else begin
        s_next[i] = S_W'(s3_prod[i][0]) + S_W'(s3_prod[i][1]) + S_W'(s3_prod[i][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin.valid <= 1'b0;
    end else begin
      fin.valid <= s3_valid;
    end
    fin.op <= s3_op;
    for (int i = 0; i < 3; i++) begin
      fin.dv[i] <= dv_next[i];
      fin.s[i]  <= s_next[i];
    end
  end

endmodule

### hw/rtl/svt_round.sv
`timescale 1ns / 1ps
module svt_round
  import svt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  svt_fin_t fin,
  output logic     done,
  output svt_out_t result
);

  localparam logic signed [DV_W-1:0] HALF_TOP = DV_W'(1) <<< (RND_TOP - 1);
  localparam logic signed [S_W-1:0]  HALF_BOT = S_W'(1) <<< (RND_BOT - 1);

  logic signed [DV_W-1:0]  dsum [3];
  logic signed [S_W-1:0]   ssum [3];
  logic signed [SAT_W-1:0] rt [3];
  logic signed [SAT_W-1:0] rs [3];
  logic signed [SAT_W-1:0] tv [3];
  logic signed [SAT_W-1:0] bv [3];
  logic [COMP_W:0]         ts [3];
  logic [COMP_W:0]         bs [3];
  svt_out_t                result_next;

  // clamp to 16 bits, flag in the top bit
  function automatic logic [COMP_W:0] sat16(input logic signed [SAT_W-1:0] v);
    logic [COMP_W:0] res;
    if (v > SAT_W'(32767)) begin
      res = {1'b1, 16'h7fff};
    end else if (v < -SAT_W'(32768)) begin
      res = {1'b1, 16'h8000};
    end else begin
      res = {1'b0, v[COMP_W-1:0]};
    end
    return res;
  endfunction

  // add half then floor: ties go toward plus infinity
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsum[i] = $signed(fin.dv[i]) + HALF_TOP;
      ssum[i] = $signed(fin.s[i]) + HALF_BOT;
      rt[i] = SAT_W'($signed(dsum[i][DV_W-1:RND_TOP]));
      rs[i] = SAT_W'($signed(ssum[i][S_W-1:RND_BOT]));
      tv[i] = '0;
      bv[i] = '0;
    end
    unique case (fin.op)
      OP_MOTION, OP_INV_MOTION: begin
        tv = rt;
        bv = rs;
      end
      OP_FORCE, OP_INV_FORCE: begin
        tv = rs;
        bv = rt;
      end
      OP_POINT, OP_INV_POINT: begin
        tv = rt;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      ts[i] = sat16(tv[i]);
      bs[i] = sat16(bv[i]);
    end
    result_next.out_0     = ts[0][COMP_W-1:0];
    result_next.out_1     = ts[1][COMP_W-1:0];
    result_next.out_2     = ts[2][COMP_W-1:0];
    result_next.out_3     = bs[0][COMP_W-1:0];
    result_next.out_4     = bs[1][COMP_W-1:0];
    result_next.out_5     = bs[2][COMP_W-1:0];
    result_next.saturated = ts[0][COMP_W] | ts[1][COMP_W] | ts[2][COMP_W] |
                            bs[0][COMP_W] | bs[1][COMP_W] | bs[2][COMP_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
    result <= result_next;
  end

endmodule
